// ----- design/mcpid_pkg.sv -----
// mcpid_pkg: payload types, work-queue types and fixed widths of the PID step unit.
// Used by every module of the block; depends on nothing.
package mcpid_pkg;

  // Fixed field and datapath widths
  localparam int unsigned CH_W    = 4;
  localparam int unsigned MEAS_W  = 16;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned ERR_W   = 17;   // difference of two int16 values
  localparam int unsigned ESTO_W  = 18;   // stored error width
  localparam int unsigned SUM_W   = 32;   // positional integral
  localparam int unsigned FRAC_W  = 16;   // Q8.16 gains
  localparam int unsigned DIFF_W  = 21;   // first and second differences
  localparam int unsigned IOP_W   = 33;   // integral operand (error or saturated sum)
  localparam int unsigned ACC_W   = 60;   // Q16 accumulator

  // Work queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    MODE_INCREMENTAL = 1'b0,
    MODE_POSITIONAL  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic [CH_W-1:0]           channel;
    logic signed [MEAS_W-1:0]  measured;
    logic signed [MEAS_W-1:0]  target;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
  } in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      saturated;
  } out_t;

  // Classified item as it sits in the queue
  typedef struct packed {
    mode_t                     mode;
    logic                      skip;     // channel out of range: state is not written
    logic [CH_W-1:0]           channel;
    logic signed [ERR_W-1:0]   err;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
  } work_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    work_t item;
  } q_head_t;

endpackage

// ----- design/mcpid_front.sv -----
// mcpid_front: accepts input transfers, forms the signed error and flags
// out-of-range channels before the work queue. Depends on mcpid_pkg.
module mcpid_front
  import mcpid_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  input  logic  q_full,
  output logic  q_push,
  output work_t q_item
);

  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  logic signed [ERR_W-1:0] meas_x;
  logic signed [ERR_W-1:0] targ_x;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Error sign follows the form: positional takes measured minus target
  assign meas_x = ERR_W'(in_data.measured);
  assign targ_x = ERR_W'(in_data.target);

  always_comb begin
    q_item.mode    = in_data.mode;
    q_item.skip    = ({3'b000, in_data.channel} >= CH_LIMIT);
    q_item.channel = in_data.channel;
    q_item.kp      = in_data.kp;
    q_item.ki      = in_data.ki;
    q_item.kd      = in_data.kd;
    if (in_data.mode == MODE_POSITIONAL) begin
      q_item.err = meas_x - targ_x;
    end else begin
      q_item.err = targ_x - meas_x;
    end
  end

endmodule

// ----- design/mcpid_queue.sv -----
// mcpid_queue: short register queue between front and back so each side
// stalls on its own. Depends on mcpid_pkg.
module mcpid_queue
  import mcpid_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  work_t   push_item,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  work_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic                do_push, do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head.valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload slots, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/mcpid_back.sv -----
// mcpid_back: per-channel state memory and the five-stage PID datapath
// (read, operands, multiply, sum, round/clip/write back). Depends on mcpid_pkg.
module mcpid_back
  import mcpid_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_head_t q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    out_data
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    logic signed [ESTO_W-1:0]  e1;
    logic signed [ESTO_W-1:0]  e2;
    logic signed [SUM_W-1:0]   sum;
    logic signed [DRIVE_W-1:0] drive;
  } chan_state_t;

  // Item info that rides along behind the operands
  typedef struct packed {
    logic                      skip;
    logic [CH_W-1:0]           channel;
    logic signed [ESTO_W-1:0]  e1;
    logic signed [ESTO_W-1:0]  e2;
    logic signed [SUM_W-1:0]   sum;
    logic                      isat;
  } tag_t;

  // ---------------------------------------------------------------- state
  chan_state_t        mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;

  // ---------------------------------------------------------------- stages
  logic        p1_valid_r, p2_valid_r, p3_valid_r, p4_valid_r;
  work_t       p1_item_r;
  chan_state_t rd_data_r;
  logic        rd_vld_r;

  tag_t                       p2_tag_r, p3_tag_r, p4_tag_r;
  logic [GAIN_W-1:0]          p2_kp_r, p2_ki_r, p2_kd_r;
  logic signed [DIFF_W-1:0]   p2_ap_r, p2_ad_r;
  logic signed [IOP_W-1:0]    p2_ai_r;
  logic signed [DRIVE_W-1:0]  p2_base_r, p3_base_r;

  logic signed [GAIN_W+DIFF_W:0] p3_pp_r, p3_pd_r;
  logic signed [GAIN_W+IOP_W:0]  p3_pi_r;
  logic signed [ACC_W-1:0]       p4_acc_r;

  out_t out_r;
  logic out_valid_r;

  logic adv, hazard, issue;
  logic [IDX_W+CH_W-1:0] rd_ext, wr_ext;
  logic [IDX_W-1:0]      rd_idx, wr_idx;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Whole pipeline moves unless a finished result is held back
  assign adv = !out_valid_r || !out_stall;

  // Same-channel item still in flight: wait until its write-back is done
  always_comb begin
    hazard = 1'b0;
    if (!q_head.item.skip) begin
      if (p1_valid_r && !p1_item_r.skip && p1_item_r.channel == q_head.item.channel)
        hazard = 1'b1;
      if (p2_valid_r && !p2_tag_r.skip && p2_tag_r.channel == q_head.item.channel)
        hazard = 1'b1;
      if (p3_valid_r && !p3_tag_r.skip && p3_tag_r.channel == q_head.item.channel)
        hazard = 1'b1;
      if (p4_valid_r && !p4_tag_r.skip && p4_tag_r.channel == q_head.item.channel)
        hazard = 1'b1;
    end
  end

  assign issue = q_head.valid && adv && !hazard;
  assign q_pop = issue;

  assign rd_ext = {{IDX_W{1'b0}}, q_head.item.channel};
  assign rd_idx = rd_ext[IDX_W-1:0];
  assign wr_ext = {{IDX_W{1'b0}}, p4_tag_r.channel};
  assign wr_idx = wr_ext[IDX_W-1:0];

  // ---------------------------------------------------------------- stage 1: operands
  chan_state_t             cur;
  logic signed [ERR_W-1:0] e;
  logic signed [SUM_W:0]   sum_wide;
  logic                    sum_ovf;
  logic signed [SUM_W-1:0] sum_sat;
  tag_t                    tag1;
  logic signed [DIFF_W-1:0] ap1, ad1;
  logic signed [IOP_W-1:0]  ai1;
  logic signed [DRIVE_W-1:0] base1;

  always_comb begin
    // entries never written read as zero
    cur      = rd_vld_r ? rd_data_r : '0;
    e        = p1_item_r.err;
    sum_wide = (SUM_W+1)'(cur.sum) + (SUM_W+1)'(e);
    sum_ovf  = sum_wide[SUM_W] ^ sum_wide[SUM_W-1];
    if (sum_ovf) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end

    tag1.skip    = p1_item_r.skip;
    tag1.channel = p1_item_r.channel;
    tag1.e1      = ESTO_W'(e);
    if (p1_item_r.mode == MODE_POSITIONAL) begin
      ap1        = DIFF_W'(e);
      ai1        = IOP_W'(sum_sat);
      ad1        = DIFF_W'(e) - DIFF_W'(cur.e1);
      base1      = '0;
      tag1.e2    = cur.e2;
      tag1.sum   = sum_sat;
      tag1.isat  = sum_ovf;
    end else begin
      ap1        = DIFF_W'(e) - DIFF_W'(cur.e1);
      ai1        = IOP_W'(e);
      ad1        = DIFF_W'(e) - (DIFF_W'(cur.e1) <<< 1) + DIFF_W'(cur.e2);
      base1      = cur.drive;
      tag1.e2    = cur.e1;
      tag1.sum   = cur.sum;
      tag1.isat  = 1'b0;
    end
  end

  // ---------------------------------------------------------------- stage 2/3/4 logic
  logic signed [GAIN_W+DIFF_W:0] pp2, pd2;
  logic signed [GAIN_W+IOP_W:0]  pi2;
  logic signed [ACC_W-1:0]       acc3;

  assign pp2 = $signed({1'b0, p2_kp_r}) * p2_ap_r;
  assign pi2 = $signed({1'b0, p2_ki_r}) * p2_ai_r;
  assign pd2 = $signed({1'b0, p2_kd_r}) * p2_ad_r;

  assign acc3 = (ACC_W'(p3_base_r) <<< FRAC_W) + ACC_W'(p3_pp_r)
              + ACC_W'(p3_pi_r) + ACC_W'(p3_pd_r);

  // Truncate toward zero, then clip to int16
  logic signed [ACC_W-FRAC_W-1:0] quo, quo_t;
  logic                           rnd_up;
  logic signed [DRIVE_W-1:0]      drive4;
  logic                           dsat4;
  localparam logic signed [ACC_W-FRAC_W-1:0] D_MAX = (ACC_W-FRAC_W)'(32767);
  localparam logic signed [ACC_W-FRAC_W-1:0] D_MIN = -(ACC_W-FRAC_W)'(32768);

  always_comb begin
    quo    = p4_acc_r[ACC_W-1:FRAC_W];
    rnd_up = p4_acc_r[ACC_W-1] && (p4_acc_r[FRAC_W-1:0] != '0);
    quo_t  = quo + $signed({{(ACC_W-FRAC_W-1){1'b0}}, rnd_up});
    dsat4  = 1'b1;
    if (quo_t > D_MAX) begin
      drive4 = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (quo_t < D_MIN) begin
      drive4 = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive4 = quo_t[DRIVE_W-1:0];
      dsat4  = 1'b0;
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      p4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else if (adv) begin
      p1_valid_r  <= issue;
      p2_valid_r  <= p1_valid_r;
      p3_valid_r  <= p2_valid_r;
      p4_valid_r  <= p3_valid_r;
      out_valid_r <= p4_valid_r;
      if (p4_valid_r && !p4_tag_r.skip) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      if (issue) begin
        p1_item_r <= q_head.item;
        rd_data_r <= mem[rd_idx];
        rd_vld_r  <= vld_r[rd_idx];
      end
      p2_tag_r  <= tag1;
      p2_kp_r   <= p1_item_r.kp;
      p2_ki_r   <= p1_item_r.ki;
      p2_kd_r   <= p1_item_r.kd;
      p2_ap_r   <= ap1;
      p2_ai_r   <= ai1;
      p2_ad_r   <= ad1;
      p2_base_r <= base1;

      p3_tag_r  <= p2_tag_r;
      p3_base_r <= p2_base_r;
      p3_pp_r   <= pp2;
      p3_pi_r   <= pi2;
      p3_pd_r   <= pd2;

      p4_tag_r  <= p3_tag_r;
      p4_acc_r  <= acc3;

      if (p4_tag_r.skip) begin
        out_r <= '0;
      end else begin
        out_r.drive     <= drive4;
        out_r.saturated <= dsat4 | p4_tag_r.isat;
      end
    end
  end

  // State write-back on leaving the last stage
  always_ff @(posedge clk) begin
    if (adv && p4_valid_r && !p4_tag_r.skip) begin
      mem[wr_idx] <= '{e1: p4_tag_r.e1, e2: p4_tag_r.e2,
                       sum: p4_tag_r.sum, drive: drive4};
    end
  end

endmodule

// ----- design/multi_channel_pid_step_unit.sv -----
// multi_channel_pid_step_unit: top level of the per-channel PID step block.
// Instantiates mcpid_front, mcpid_queue and mcpid_back; depends on mcpid_pkg.
//
//   channel   ports                         payload
//   input     in_valid / in_stall           in_data  (in_t)
//   result    out_valid / out_stall         out_data (out_t)
//
// Items on different channels flow at one per cycle while out_stall is low.
// The input transfer writes the queue; then come the state read, operands,
// multiply, sum and round/clip registers. An item whose channel is still in
// the pipeline waits in the queue until that write-back, so same-channel items
// never overlap. State resets to zero through per-channel valid bits, with no
// clearing pass. A stalled result freezes the back end; the queue keeps taking
// transfers until its two entries are full.
module multi_channel_pid_step_unit
  import mcpid_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic    q_full, q_push, q_pop;
  work_t   q_item;
  q_head_t q_head;

  mcpid_front #(.CHANNELS(CHANNELS)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  mcpid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  mcpid_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/mcpid_checker.sv -----
// mcpid_checker: port-level assertions for multi_channel_pid_step_unit,
// bound to the top level below. Depends on mcpid_pkg.
module mcpid_checker
  import mcpid_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Reset empties the pipeline and the queue
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled straight after reset");

  // Queue can only fill through an input transfer on the edge before
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall rose without a transfer");

endmodule

bind multi_channel_pid_step_unit mcpid_checker u_chk (.*);
